@@ sv/laags_pkg.sv @@
package laags_pkg;

  typedef logic signed [19:0] score_t;
  typedef logic signed [8:0]  pen_t;

  localparam score_t SCORE_NEG_INF  = 20'sh80000;
  localparam score_t SCORE_MIN      = 20'sh80001;
  localparam score_t SCORE_MAX      = 20'sh7FFFF;
  localparam score_t SCORE_BEST_CAP = 20'sh1FFFF;
  localparam score_t SCORE_ZERO     = 20'sh00000;

  localparam logic [1:0] CFG_MATCH      = 2'd0;
  localparam logic [1:0] CFG_MISMATCH   = 2'd1;
  localparam logic [1:0] CFG_GAP_OPEN   = 2'd2;
  localparam logic [1:0] CFG_GAP_EXTEND = 2'd3;

  typedef struct packed {
    logic signed [7:0] match_bonus;
    logic signed [7:0] mismatch_penalty;
    pen_t              open_extend;
    pen_t              extend;
  } score_cfg_t;

  typedef struct packed {
    score_t best;
    score_t hgap;
  } col_entry_t;

  function automatic score_t sat_add(input score_t a, input pen_t b);
    logic signed [20:0] s;
    s = 21'(a) + 21'(b);
    if (s > 21'(SCORE_MAX)) begin
      return SCORE_MAX;
    end else if (s < 21'(SCORE_MIN)) begin
      return SCORE_MIN;
    end else begin
      return s[19:0];
    end
  endfunction

  function automatic score_t add_inf(input score_t a, input pen_t b);
    if (a == SCORE_NEG_INF) begin
      return SCORE_NEG_INF;
    end else begin
      return sat_add(a, b);
    end
  endfunction

  function automatic score_t max_score(input score_t a, input score_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ sv/laags_cell.sv @@
module laags_cell import laags_pkg::*; (
  input  score_cfg_t cfg,
  input  logic       sym_eq,
  input  score_t     up,
  input  score_t     hgap,
  input  score_t     diag,
  input  score_t     left_d,
  input  score_t     q_prev,
  output score_t     p,
  output score_t     q,
  output score_t     d
);

  score_t diag_sum;
  pen_t   sub_score;

  assign sub_score = sym_eq ? pen_t'(cfg.match_bonus) : pen_t'(cfg.mismatch_penalty);

  always_comb begin
    p        = max_score(add_inf(up, cfg.open_extend), add_inf(hgap, cfg.extend));
    q        = max_score(add_inf(left_d, cfg.open_extend), add_inf(q_prev, cfg.extend));
    diag_sum = sat_add(diag, sub_score);
    d        = max_score(max_score(p, q), max_score(diag_sum, SCORE_ZERO));
  end

endmodule

@@ sv/local_alignment_affine_gap_score_core.sv @@
// Smith-Waterman local alignment score with affine gaps. Query symbols
// (func 0) are appended one per cycle while the block is idle, up to
// MAX_QUERY; further ones are dropped and flagged. A target symbol (func 1)
// sweeps the stored column once through a single cell unit, one query
// position per cycle against a one-read/one-write column memory, and holds
// the block until its sweep is done; with an empty query it does not sweep.
// A last target holds the block longer while the previous result still
// waits in the output register. The last target symbol returns the best
// score, saturated to 17 bits, and then clears the column state.
module local_alignment_affine_gap_score_core import laags_pkg::*; #(
  parameter int MAX_QUERY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        func,
  input  logic [7:0]  symbol,
  input  logic        last,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [16:0] best_score,
  output logic        query_overflow
);

  localparam int AW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int LW = $clog2(MAX_QUERY + 1);
  localparam logic [LW-1:0] MAXL = LW'(MAX_QUERY);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state;
  logic [LW-1:0] length;
  logic [LW-1:0] eff_len;
  logic          complete;
  logic          overflow_seen;
  logic          cols_valid;
  logic [16:0]   best_so_far;
  logic [16:0]   d_cap;

  logic [LW-1:0] rj;
  logic [AW-1:0] cj;
  logic          cvalid;
  logic          rd_en;
  logic [7:0]    tsym;
  logic          tlast;
  score_t        q_run;
  score_t        left_d;
  score_t        diag;

  logic signed [7:0] match_bonus;
  logic signed [7:0] mismatch_penalty;
  logic signed [7:0] gap_open_penalty;
  logic signed [7:0] gap_extend_penalty;
  score_cfg_t        cfg;

  col_entry_t col_mem [MAX_QUERY];
  logic [7:0] query_mem [MAX_QUERY];
  col_entry_t col_rd;
  logic [7:0] q_rd;

  score_t up;
  score_t hgap;
  score_t cell_p;
  score_t cell_q;
  score_t cell_d;

  logic accept;
  logic q_write;
  logic out_free;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != ST_IDLE) || (func && last && result_valid);
  assign out_free   = !result_valid || !result_stall;
  assign eff_len    = complete ? '0 : length;
  assign q_write    = accept && !func && (eff_len < MAXL);
  assign rd_en      = (state == ST_RUN) && (rj != length);

  assign cfg.match_bonus      = match_bonus;
  assign cfg.mismatch_penalty = mismatch_penalty;
  assign cfg.open_extend      = pen_t'(gap_open_penalty) + pen_t'(gap_extend_penalty);
  assign cfg.extend           = pen_t'(gap_extend_penalty);

  assign up    = cols_valid ? col_rd.best : SCORE_ZERO;
  assign hgap  = cols_valid ? col_rd.hgap : SCORE_NEG_INF;
  assign d_cap = (cell_d > SCORE_BEST_CAP) ? 17'h1FFFF : cell_d[16:0];

  laags_cell u_cell (
    .cfg    (cfg),
    .sym_eq (q_rd == tsym),
    .up     (up),
    .hgap   (hgap),
    .diag   (diag),
    .left_d (left_d),
    .q_prev (q_run),
    .p      (cell_p),
    .q      (cell_q),
    .d      (cell_d)
  );

  always_ff @(posedge clk) begin
    if (q_write) begin
      query_mem[eff_len[AW-1:0]] <= symbol;
    end
    if (cvalid) begin
      col_mem[cj] <= '{best: cell_d, hgap: cell_p};
    end
    if (rd_en) begin
      col_rd <= col_mem[rj[AW-1:0]];
      q_rd   <= query_mem[rj[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_bonus        <= 8'sd2;
      mismatch_penalty   <= -8'sd1;
      gap_open_penalty   <= -8'sd3;
      gap_extend_penalty <= -8'sd1;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_MATCH:      match_bonus        <= cfg_data;
        CFG_MISMATCH:   mismatch_penalty   <= cfg_data;
        CFG_GAP_OPEN:   gap_open_penalty   <= cfg_data;
        CFG_GAP_EXTEND: gap_extend_penalty <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      length        <= '0;
      complete      <= 1'b0;
      overflow_seen <= 1'b0;
      cols_valid    <= 1'b0;
      best_so_far   <= '0;
      result_valid  <= 1'b0;
      cvalid        <= 1'b0;
      rj            <= '0;
    end else begin
      if (result_valid && !result_stall && !((state == ST_DONE) && tlast)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && !func) begin
            if (complete) begin
              cols_valid  <= 1'b0;
              best_so_far <= '0;
            end
            if (eff_len < MAXL) begin
              length <= eff_len + 1'b1;
            end else begin
              length <= eff_len;
            end
            overflow_seen <= (eff_len >= MAXL) || (overflow_seen && !complete);
            complete      <= last;
          end else if (accept) begin
            complete <= 1'b1;
            if (length == '0) begin
              if (last) begin
                best_score     <= best_so_far;
                query_overflow <= overflow_seen;
                result_valid   <= 1'b1;
                best_so_far    <= '0;
                cols_valid     <= 1'b0;
              end
            end else begin
              state  <= ST_RUN;
              rj     <= '0;
              tsym   <= symbol;
              tlast  <= last;
              q_run  <= SCORE_NEG_INF;
              left_d <= SCORE_ZERO;
              diag   <= SCORE_ZERO;
            end
          end
        end
        ST_RUN: begin
          if (rd_en) begin
            rj <= rj + 1'b1;
          end
          cvalid <= rd_en;
          cj     <= rj[AW-1:0];
          if (cvalid) begin
            diag   <= up;
            left_d <= cell_d;
            q_run  <= cell_q;
            if (d_cap > best_so_far) begin
              best_so_far <= d_cap;
            end
            if (!rd_en) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!tlast) begin
            cols_valid <= 1'b1;
            state      <= ST_IDLE;
          end else if (out_free) begin
            best_score     <= best_so_far;
            query_overflow <= overflow_seen;
            result_valid   <= 1'b1;
            best_so_far    <= '0;
            cols_valid     <= 1'b0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (length == MAXL))
    else $error("overflow flagged with room left in query store");

  a_cell_in_range: assert property (@(posedge clk) disable iff (rst)
    cvalid |-> (LW'(cj) < length))
    else $error("column write beyond query length");

  a_sweep_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && $past(state == ST_RUN) |-> $stable(length) && $stable(tsym))
    else $error("query or target changed during sweep");

  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> (best_so_far == '0) && !cols_valid)
    else $error("running maximum not cleared with result");

endmodule
